[design/mvma_pkg.sv]
`timescale 1ns / 1ps
// mvma_pkg: shared types and constants of the matrix-vector multiply-add block.
// No dependencies; every other design file but mvma_xstore uses this package.
package mvma_pkg;

    // Fixed field widths
    localparam int SCALE_W    = 16;   // alpha / beta, signed Q7.8
    localparam int FRAC_W     = 8;    // fraction bits of Q7.8
    localparam int ACC_W      = 40;   // dot product accumulator
    localparam int ACC_SPLIT  = 24;   // low part of the accumulator for the alpha multiply
    localparam int COL_CNT_W  = 9;
    localparam int ROW_CNT_W  = 11;
    localparam int ROW_NUM_W  = 10;
    localparam int IDX_W      = 8;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    // Item kinds
    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_MATRIX = 1'b1;

    // Register map
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ALPHA = 4'd0,
        REG_BETA  = 4'd1,
        REG_COLS  = 4'd2,
        REG_ROWS  = 4'd3
    } cfg_reg_t;

    // Reset values
    localparam logic signed [SCALE_W-1:0] ALPHA_RST = 16'sd256;
    localparam logic signed [SCALE_W-1:0] BETA_RST  = 16'sd0;
    localparam logic [COL_CNT_W-1:0]      COLS_RST  = 9'd256;
    localparam logic [ROW_CNT_W-1:0]      ROWS_RST  = 11'd1024;

    typedef struct packed {
        logic signed [SCALE_W-1:0] alpha_scale;
        logic signed [SCALE_W-1:0] beta_scale;
        logic [COL_CNT_W-1:0]      column_count;
        logic [ROW_CNT_W-1:0]      row_count;
    } cfg_t;

    typedef struct packed {
        logic [ROW_NUM_W-1:0] row_number;
        logic                 last_row;
    } row_tag_t;

endpackage

[design/mvma_if.sv]
`timescale 1ns / 1ps
// mvma_if: valid/ready channel interfaces (item in, result out, config write).
// Depends on mvma_pkg for field widths.
interface mvma_item_if #(parameter int DATA_WIDTH = 16) ();
    logic                               valid;
    logic                               ready;
    logic                               action;
    logic [mvma_pkg::IDX_W-1:0]         vector_index;
    logic signed [DATA_WIDTH-1:0]       data_value;
    logic signed [DATA_WIDTH-1:0]       y_old;

    modport source (output valid, action, vector_index, data_value, y_old, input ready);
    modport sink   (input valid, action, vector_index, data_value, y_old, output ready);
endinterface

interface mvma_result_if #(parameter int DATA_WIDTH = 16) ();
    logic                               valid;
    logic                               ready;
    logic signed [DATA_WIDTH-1:0]       y_new;
    logic [mvma_pkg::ROW_NUM_W-1:0]     row_number;
    logic                               last_row;

    modport source (output valid, y_new, row_number, last_row, input ready);
    modport sink   (input valid, y_new, row_number, last_row, output ready);
endinterface

interface mvma_cfg_if ();
    logic                               valid;
    logic                               ready;
    logic [mvma_pkg::CFG_IDX_W-1:0]     index;
    logic [mvma_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[design/mvma_cfg.sv]
`timescale 1ns / 1ps
// mvma_cfg: configuration register file (alpha, beta, column and row counts).
// Depends on mvma_pkg and mvma_if.
module mvma_cfg (
    input  logic           clk,
    input  logic           rst_n,
    mvma_cfg_if.sink       cfg,
    output mvma_pkg::cfg_t regs
);
    import mvma_pkg::*;

    cfg_t regs_reg;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.alpha_scale  <= ALPHA_RST;
            regs_reg.beta_scale   <= BETA_RST;
            regs_reg.column_count <= COLS_RST;
            regs_reg.row_count    <= ROWS_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_ALPHA: regs_reg.alpha_scale  <= $signed(cfg.data[SCALE_W-1:0]);
                REG_BETA:  regs_reg.beta_scale   <= $signed(cfg.data[SCALE_W-1:0]);
                REG_COLS:  regs_reg.column_count <= cfg.data[COL_CNT_W-1:0];
                REG_ROWS:  regs_reg.row_count    <= cfg.data[ROW_CNT_W-1:0];
                default:   ;
            endcase
        end
    end

endmodule

[design/mvma_xstore.sv]
`timescale 1ns / 1ps
// mvma_xstore: x vector memory, one write and one registered read per cycle.
// No package dependency.
module mvma_xstore #(
    parameter int DEPTH      = 256,
    parameter int DATA_WIDTH = 16,
    localparam int AW        = $clog2(DEPTH)
) (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [AW-1:0]                wr_addr,
    input  logic signed [DATA_WIDTH-1:0] wr_data,
    input  logic                         rd_en,
    input  logic [AW-1:0]                rd_addr,
    output logic signed [DATA_WIDTH-1:0] rd_data
);
    logic signed [DATA_WIDTH-1:0] mem [DEPTH];
    logic signed [DATA_WIDTH-1:0] rd_data_reg;

    assign rd_data = rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

[design/mvma_mac.sv]
`timescale 1ns / 1ps
// mvma_mac: column/row tracking, x lookup, product stage and dot accumulator.
// Depends on mvma_pkg, mvma_if and mvma_xstore.
module mvma_mac #(
    parameter int MAX_COLS   = 256,
    parameter int MAX_ROWS   = 1024,
    parameter int DATA_WIDTH = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    mvma_item_if.sink                          item,
    input  mvma_pkg::cfg_t                     cfg,
    output logic                               tok_valid,
    input  logic                               tok_ready,
    output logic signed [mvma_pkg::ACC_W-1:0]  tok_acc,
    output logic signed [DATA_WIDTH-1:0]       tok_y_old,
    output mvma_pkg::row_tag_t                 tok_tag
);
    import mvma_pkg::*;

    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int CCW    = $clog2(MAX_COLS + 1);
    localparam int RCW    = $clog2(MAX_ROWS + 1);
    localparam int NCW    = (COL_CNT_W > CCW) ? COL_CNT_W : CCW;
    localparam int NRW    = (ROW_CNT_W > RCW) ? ROW_CNT_W : RCW;
    localparam int PROD_W = 2 * DATA_WIDTH;

    // Position state
    logic [COL_W-1:0] col_pos_reg;
    logic [ROW_W-1:0] row_pos_reg;

    // Stage F: accepted matrix word, x read in flight
    logic                         f_v_reg;
    logic signed [DATA_WIDTH-1:0] f_data_reg;
    logic signed [DATA_WIDTH-1:0] f_y_old_reg;
    logic                         f_end_reg;
    row_tag_t                     f_tag_reg;
    logic signed [DATA_WIDTH-1:0] x_rd;

    // Stage M: product
    logic                         m_v_reg;
    logic signed [PROD_W-1:0]     m_prod_reg;
    logic signed [DATA_WIDTH-1:0] m_y_old_reg;
    logic                         m_end_reg;
    row_tag_t                     m_tag_reg;

    logic signed [ACC_W-1:0]      acc_reg;
    logic signed [ACC_W-1:0]      acc_sum;
    logic signed [PROD_W-1:0]     prod_next;

    logic [NCW-1:0] cols_raw;
    logic [NCW-1:0] ncols;
    logic [NCW-1:0] col_inc;
    logic [NRW-1:0] rows_raw;
    logic [NRW-1:0] nrows;
    logic [NRW-1:0] row_inc;
    logic           row_end_new;
    logic           last_new;

    logic m_take;
    logic m_ready;
    logic f_ready;
    logic acc_in;
    logic mat_in;
    logic load_in;

    // Count clamping
    assign cols_raw = NCW'(cfg.column_count);
    assign rows_raw = NRW'(cfg.row_count);

    always_comb
    begin
        if (cols_raw == '0)
        begin
            ncols = NCW'(1);
        end
        else if (cols_raw > NCW'(MAX_COLS))
        begin
            ncols = NCW'(MAX_COLS);
        end
        else
        begin
            ncols = cols_raw;
        end

        if (rows_raw == '0)
        begin
            nrows = NRW'(1);
        end
        else if (rows_raw > NRW'(MAX_ROWS))
        begin
            nrows = NRW'(MAX_ROWS);
        end
        else
        begin
            nrows = rows_raw;
        end
    end

    assign col_inc     = NCW'(col_pos_reg) + NCW'(1);
    assign row_inc     = NRW'(row_pos_reg) + NRW'(1);
    assign row_end_new = (col_inc >= ncols);
    assign last_new    = (row_inc >= nrows);

    // Handshake chain
    assign m_take     = m_v_reg && (!m_end_reg || tok_ready);
    assign m_ready    = !m_v_reg || m_take;
    assign f_ready    = !f_v_reg || m_ready;
    assign item.ready = f_ready;

    assign acc_in  = item.valid && f_ready;
    assign mat_in  = acc_in && (item.action == ACT_MATRIX);
    assign load_in = acc_in && (item.action == ACT_LOAD)
                     && (NCW'(item.vector_index) < NCW'(MAX_COLS));

    mvma_xstore #(
        .DEPTH      (MAX_COLS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_xstore (
        .clk     (clk),
        .wr_en   (load_in),
        .wr_addr (COL_W'(item.vector_index)),
        .wr_data (item.data_value),
        .rd_en   (mat_in),
        .rd_addr (col_pos_reg),
        .rd_data (x_rd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_pos_reg <= '0;
            row_pos_reg <= '0;
            f_v_reg     <= 1'b0;
            m_v_reg     <= 1'b0;
            acc_reg     <= '0;
        end
        else
        begin
            if (mat_in)
            begin
                if (row_end_new)
                begin
                    col_pos_reg <= '0;
                    row_pos_reg <= last_new ? '0 : row_inc[ROW_W-1:0];
                end
                else
                begin
                    col_pos_reg <= col_inc[COL_W-1:0];
                end
            end
            if (f_ready)
            begin
                f_v_reg <= mat_in;
            end
            if (m_ready)
            begin
                m_v_reg <= f_v_reg;
            end
            if (m_take)
            begin
                acc_reg <= m_end_reg ? '0 : acc_sum;
            end
        end
    end

    assign prod_next = f_data_reg * x_rd;

    always_ff @(posedge clk)
    begin
        if (mat_in)
        begin
            f_data_reg           <= item.data_value;
            f_y_old_reg          <= item.y_old;
            f_end_reg            <= row_end_new;
            f_tag_reg.row_number <= ROW_NUM_W'(row_pos_reg);
            f_tag_reg.last_row   <= last_new;
        end
        if (m_ready && f_v_reg)
        begin
            m_prod_reg  <= prod_next;
            m_y_old_reg <= f_y_old_reg;
            m_end_reg   <= f_end_reg;
            m_tag_reg   <= f_tag_reg;
        end
    end

    // 40-bit wrapping accumulate
    assign acc_sum   = acc_reg + ACC_W'(m_prod_reg);

    assign tok_valid = m_v_reg && m_end_reg;
    assign tok_acc   = acc_sum;
    assign tok_y_old = m_y_old_reg;
    assign tok_tag   = m_tag_reg;

endmodule

[design/mvma_scale.sv]
`timescale 1ns / 1ps
// mvma_scale: row-end pipeline, alpha*sum + beta*y_old, round to Q7.8, saturate.
// Depends on mvma_pkg.
module mvma_scale #(
    parameter int DATA_WIDTH = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  mvma_pkg::cfg_t                     cfg,
    input  logic                               tok_valid,
    output logic                               tok_ready,
    input  logic signed [mvma_pkg::ACC_W-1:0]  tok_acc,
    input  logic signed [DATA_WIDTH-1:0]       tok_y_old,
    input  mvma_pkg::row_tag_t                 tok_tag,
    output logic                               push_valid,
    input  logic                               push_ready,
    output logic signed [DATA_WIDTH-1:0]       push_y,
    output mvma_pkg::row_tag_t                 push_tag
);
    import mvma_pkg::*;

    localparam int LO_W  = ACC_SPLIT;
    localparam int HI_W  = ACC_W - ACC_SPLIT;
    localparam int PLO_W = SCALE_W + LO_W + 1;
    localparam int PHI_W = SCALE_W + HI_W;
    localparam int PA_W  = SCALE_W + ACC_W;
    localparam int BY_W  = SCALE_W + DATA_WIDTH;
    localparam int TOT_W = ((PA_W > BY_W + FRAC_W) ? PA_W : BY_W + FRAC_W) + 1;
    localparam int RND_W = TOT_W + 1;

    localparam logic signed [RND_W-1:0] RND_HALF = RND_W'(1) <<< (2 * FRAC_W - 1);
    localparam logic signed [RND_W-1:0] SAT_HI =
        $signed({{(RND_W - DATA_WIDTH + 1){1'b0}}, {(DATA_WIDTH - 1){1'b1}}});
    localparam logic signed [RND_W-1:0] SAT_LO =
        $signed({{(RND_W - DATA_WIDTH + 1){1'b1}}, {(DATA_WIDTH - 1){1'b0}}});

    logic signed [SCALE_W-1:0] alpha;
    logic signed [SCALE_W-1:0] beta;

    logic                         e1_v_reg;
    logic signed [ACC_W-1:0]      e1_acc_reg;
    logic signed [DATA_WIDTH-1:0] e1_y_old_reg;
    row_tag_t                     e1_tag_reg;

    logic                         e2_v_reg;
    logic signed [PLO_W-1:0]      e2_plo_reg;
    logic signed [HI_W-1:0]       e2_hi_reg;
    logic signed [DATA_WIDTH-1:0] e2_y_old_reg;
    row_tag_t                     e2_tag_reg;

    logic                         e3_v_reg;
    logic signed [PA_W-1:0]       e3_pa_reg;
    logic signed [DATA_WIDTH-1:0] e3_y_old_reg;
    row_tag_t                     e3_tag_reg;

    logic                         e4_v_reg;
    logic signed [TOT_W-1:0]      e4_total_reg;
    row_tag_t                     e4_tag_reg;

    logic signed [LO_W:0]         acc_lo;
    logic signed [PLO_W-1:0]      plo_next;
    logic signed [PHI_W-1:0]      phi;
    logic signed [PA_W-1:0]       pa_next;
    logic signed [BY_W-1:0]       by;
    logic signed [TOT_W-1:0]      total_next;
    logic signed [RND_W-1:0]      rnd;
    logic signed [RND_W-1:0]      rsh;

    logic r1;
    logic r2;
    logic r3;
    logic r4;

    assign alpha = cfg.alpha_scale;
    assign beta  = cfg.beta_scale;

    assign r4        = !e4_v_reg || push_ready;
    assign r3        = !e3_v_reg || r4;
    assign r2        = !e2_v_reg || r3;
    assign r1        = !e1_v_reg || r2;
    assign tok_ready = r1;

    // Alpha times the 40-bit sum, split in two narrow products
    assign acc_lo     = $signed({1'b0, e1_acc_reg[LO_W-1:0]});
    assign plo_next   = alpha * acc_lo;
    assign phi        = alpha * e2_hi_reg;
    assign pa_next    = (PA_W'(phi) <<< LO_W) + PA_W'(e2_plo_reg);
    assign by         = beta * e3_y_old_reg;
    assign total_next = TOT_W'(e3_pa_reg) + (TOT_W'(by) <<< FRAC_W);

    // Round half up, drop 16 fraction bits, clamp
    assign rnd = RND_W'(e4_total_reg) + RND_HALF;
    assign rsh = rnd >>> (2 * FRAC_W);

    always_comb
    begin
        if (rsh > SAT_HI)
        begin
            push_y = SAT_HI[DATA_WIDTH-1:0];
        end
        else if (rsh < SAT_LO)
        begin
            push_y = SAT_LO[DATA_WIDTH-1:0];
        end
        else
        begin
            push_y = rsh[DATA_WIDTH-1:0];
        end
    end

    assign push_valid = e4_v_reg;
    assign push_tag   = e4_tag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e1_v_reg <= 1'b0;
            e2_v_reg <= 1'b0;
            e3_v_reg <= 1'b0;
            e4_v_reg <= 1'b0;
        end
        else
        begin
            if (r1)
            begin
                e1_v_reg <= tok_valid;
            end
            if (r2)
            begin
                e2_v_reg <= e1_v_reg;
            end
            if (r3)
            begin
                e3_v_reg <= e2_v_reg;
            end
            if (r4)
            begin
                e4_v_reg <= e3_v_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (r1 && tok_valid)
        begin
            e1_acc_reg   <= tok_acc;
            e1_y_old_reg <= tok_y_old;
            e1_tag_reg   <= tok_tag;
        end
        if (r2 && e1_v_reg)
        begin
            e2_plo_reg   <= plo_next;
            e2_hi_reg    <= e1_acc_reg[ACC_W-1:LO_W];
            e2_y_old_reg <= e1_y_old_reg;
            e2_tag_reg   <= e1_tag_reg;
        end
        if (r3 && e2_v_reg)
        begin
            e3_pa_reg    <= pa_next;
            e3_y_old_reg <= e2_y_old_reg;
            e3_tag_reg   <= e2_tag_reg;
        end
        if (r4 && e3_v_reg)
        begin
            e4_total_reg <= total_next;
            e4_tag_reg   <= e3_tag_reg;
        end
    end

endmodule

[design/mvma_skid.sv]
`timescale 1ns / 1ps
// mvma_skid: two-entry output buffer; registered ready toward the datapath.
// Depends on mvma_pkg and mvma_if.
module mvma_skid #(
    parameter int DATA_WIDTH = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push_valid,
    output logic                         push_ready,
    input  logic signed [DATA_WIDTH-1:0] push_y,
    input  mvma_pkg::row_tag_t           push_tag,
    mvma_result_if.source                result
);
    import mvma_pkg::*;

    logic                         out_v_reg;
    logic signed [DATA_WIDTH-1:0] out_y_reg;
    row_tag_t                     out_tag_reg;
    logic                         skid_v_reg;
    logic signed [DATA_WIDTH-1:0] skid_y_reg;
    row_tag_t                     skid_tag_reg;
    logic                         out_free;
    logic                         push;

    assign push_ready = !skid_v_reg;
    assign push       = push_valid && !skid_v_reg;
    assign out_free   = !out_v_reg || result.ready;

    assign result.valid      = out_v_reg;
    assign result.y_new      = out_y_reg;
    assign result.row_number = out_tag_reg.row_number;
    assign result.last_row   = out_tag_reg.last_row;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_v_reg  <= skid_v_reg || push;
            skid_v_reg <= 1'b0;
        end
        else if (push)
        begin
            skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_v_reg)
            begin
                out_y_reg   <= skid_y_reg;
                out_tag_reg <= skid_tag_reg;
            end
            else if (push)
            begin
                out_y_reg   <= push_y;
                out_tag_reg <= push_tag;
            end
        end
        else if (push)
        begin
            skid_y_reg   <= push_y;
            skid_tag_reg <= push_tag;
        end
    end

endmodule

[design/matrix_vector_multiply_add_top.sv]
`timescale 1ns / 1ps
// Matrix-vector multiply-add, y = alpha*A*x + beta*y, in Q7.8 fixed point.
// Top level; depends on mvma_pkg, mvma_if, mvma_cfg, mvma_mac, mvma_scale, mvma_skid.
//
// Load x first: each word with action = load writes data_value into x[vector_index]
// (indexes at or beyond MAX_COLS are dropped). Then stream A row-major, one word per
// matrix element, each carrying the y_old of its row. The last column of a row yields
// one result word: alpha*dot + beta*y_old, rounded half up to Q7.8 and saturated,
// tagged with the row number and a last-row flag; the row counter wraps after the
// last row. Counts of 0 act as 1 and counts above MAX_COLS / MAX_ROWS are clamped.
// Throughput is one word per clock, loads and matrix elements alike, unless a stalled
// result path drops item.ready: x is read from a single memory at the accepting edge,
// one multiply-accumulate per cycle. The last column of a row goes on to its result in
// these steps: x read with the accept, then product, accumulate, two alpha partial
// products, beta add, and round into the output register.
// The output stage holds two results, so the input keeps flowing while a result waits.
// Write configuration only while the block is drained; x_store has no reset.
module matrix_vector_multiply_add_top #(
    parameter int MAX_COLS   = 256,
    parameter int MAX_ROWS   = 1024,
    parameter int DATA_WIDTH = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    mvma_item_if.sink     item,
    mvma_result_if.source result,
    mvma_cfg_if.sink      cfg
);
    import mvma_pkg::*;

    cfg_t                         regs;

    // Row-end word from the accumulator to the scaling pipeline
    logic                         tok_valid;
    logic                         tok_ready;
    logic signed [ACC_W-1:0]      tok_acc;
    logic signed [DATA_WIDTH-1:0] tok_y_old;
    row_tag_t                     tok_tag;

    // Finished result into the output buffer
    logic                         push_valid;
    logic                         push_ready;
    logic signed [DATA_WIDTH-1:0] push_y;
    row_tag_t                     push_tag;

    mvma_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    mvma_mac #(
        .MAX_COLS   (MAX_COLS),
        .MAX_ROWS   (MAX_ROWS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cfg       (regs),
        .tok_valid (tok_valid),
        .tok_ready (tok_ready),
        .tok_acc   (tok_acc),
        .tok_y_old (tok_y_old),
        .tok_tag   (tok_tag)
    );

    mvma_scale #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_scale (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (regs),
        .tok_valid  (tok_valid),
        .tok_ready  (tok_ready),
        .tok_acc    (tok_acc),
        .tok_y_old  (tok_y_old),
        .tok_tag    (tok_tag),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_y     (push_y),
        .push_tag   (push_tag)
    );

    mvma_skid #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_skid (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_y     (push_y),
        .push_tag   (push_tag),
        .result     (result)
    );

endmodule

[design/mvma_checker.sv]
`timescale 1ns / 1ps
// mvma_checker: port-level assertions for the multiply-add top, and its bind.
// Depends on mvma_pkg and matrix_vector_multiply_add_top.
module mvma_checker #(
    parameter int DATA_WIDTH = 16
) (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               item_valid,
    input logic                               item_ready,
    input logic                               item_action,
    input logic                               result_valid,
    input logic                               result_ready,
    input logic signed [DATA_WIDTH-1:0]       y_new,
    input logic [mvma_pkg::ROW_NUM_W-1:0]     row_number,
    input logic                               last_row
);
    import mvma_pkg::*;

    logic [ROW_NUM_W-1:0] exp_row_reg;
    logic [31:0]          mat_cnt_reg;
    logic [31:0]          res_cnt_reg;
    logic                 res_acc;
    logic                 mat_acc;

    assign res_acc = result_valid && result_ready;
    assign mat_acc = item_valid && item_ready && (item_action == ACT_MATRIX);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_row_reg <= '0;
            mat_cnt_reg <= '0;
            res_cnt_reg <= '0;
        end
        else
        begin
            if (res_acc)
            begin
                exp_row_reg <= last_row ? '0 : row_number + ROW_NUM_W'(1);
                res_cnt_reg <= res_cnt_reg + 32'd1;
            end
            if (mat_acc)
            begin
                mat_cnt_reg <= mat_cnt_reg + 32'd1;
            end
        end
    end

    // A waiting result stays put
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(y_new)
            && $stable(row_number) && $stable(last_row))
        else $error("result word changed while stalled");

    // Rows come out in order and restart after the last row
    a_row_order: assert property (@(posedge clk) disable iff (!rst_n)
        res_acc |-> row_number == exp_row_reg)
        else $error("row number out of sequence");

    // Every result is backed by at least one earlier matrix word
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        res_acc |-> mat_cnt_reg > res_cnt_reg)
        else $error("result without matrix input");

endmodule

bind matrix_vector_multiply_add_top mvma_checker #(
    .DATA_WIDTH (DATA_WIDTH)
) u_mvma_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .item_action  (item.action),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .y_new        (result.y_new),
    .row_number   (result.row_number),
    .last_row     (result.last_row)
);
